/* hdl/e2c_pkg.sv */
// Shared types, constants and helper functions of the equirect-to-cube sample address block.
package e2c_pkg;

  localparam int SUPERSAMPLE_DEF  = 2;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int FACE_W = 3;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int SCOL_W = 13;
  localparam int SROW_W = 12;
  localparam int SUB_W  = 2;

  localparam int FS_W       = 13;
  localparam int MW_W       = 14;
  localparam int MH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int FS_MAX     = 4096;
  localparam int MW_MAX     = 8192;
  localparam int MH_MAX     = 4096;

  localparam int FRAC   = 16;
  localparam int Q_W    = 18;
  localparam int ONE_Q  = 65536;
  localparam int HALF_Q = 32768;
  localparam int QMAX   = 131071;

  // Divider: numerator is at most 31 bits for the largest grid, divisor at most 15 bits.
  localparam int DIV_W = 32;
  localparam int DVS_W = 15;
  localparam int QB    = 18;

  localparam int SQ_W     = 37;
  localparam int SQ_STEPS = 18;

  localparam int CX_W = 21;
  localparam int A_W  = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACE_SIZE  = 2'd0,
    REG_MAP_WIDTH  = 2'd1,
    REG_MAP_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_PY = 3'd1,
    FACE_NX = 3'd2,
    FACE_NY = 3'd3,
    FACE_NZ = 3'd4,
    FACE_PZ = 3'd5
  } face_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QB-1:0]    q;
    logic             sat;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [A_W-1:0]  ang;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic              vld;
    logic [FACE_W-1:0] face;
    logic [SUB_W-1:0]  sub;
    logic              last;
  } side_t;

  // atan(2^-k)/pi in Q1.16, rounded to nearest.
  function automatic logic signed [A_W-1:0] atan_tab(input int k);
    logic signed [A_W-1:0] v;
    case (k)
      0:  v = A_W'(16384);
      1:  v = A_W'(9672);
      2:  v = A_W'(5110);
      3:  v = A_W'(2594);
      4:  v = A_W'(1302);
      5:  v = A_W'(652);
      6:  v = A_W'(326);
      7:  v = A_W'(163);
      8:  v = A_W'(81);
      9:  v = A_W'(41);
      10: v = A_W'(20);
      11: v = A_W'(10);
      12: v = A_W'(5);
      13: v = A_W'(3);
      14: v = A_W'(1);
      15: v = A_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Folds the left half plane onto the right one and flags the zero vector.
  function automatic cordic_t cordic_pre(input logic signed [CX_W-1:0] x,
                                         input logic signed [CX_W-1:0] y);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    c.x    = x;
    c.y    = y;
    c.ang  = '0;
    if (x < 0) begin
      c.ang = (y >= 0) ? A_W'(ONE_Q) : -A_W'(ONE_Q);
      c.x   = -x;
      c.y   = -y;
    end
    return c;
  endfunction

  // Quotient to Q2.16 coordinate, saturated at the top of the range.
  function automatic logic signed [Q_W-1:0] grid_val(input div_t a);
    logic signed [QB+1:0] diff;
    diff = $signed({2'b00, a.q}) - (QB+2)'(ONE_Q);
    if (a.sat || (diff > (QB+2)'(QMAX))) return Q_W'(QMAX);
    return Q_W'(diff);
  endfunction

endpackage

/* hdl/e2c_in_if.sv */
// Request channel: one cube face pixel per item.
interface e2c_in_if;
  logic                           valid;
  logic                           ready;
  logic [e2c_pkg::FACE_W-1:0]     face;
  logic [e2c_pkg::COL_W-1:0]      col;
  logic [e2c_pkg::ROW_W-1:0]      row;

  modport source (output valid, face, col, row, input ready);
  modport sink   (input valid, face, col, row, output ready);
endinterface

/* hdl/e2c_out_if.sv */
// Result channel: one sphere map sample address per item.
interface e2c_out_if;
  logic                           valid;
  logic                           ready;
  logic [e2c_pkg::SCOL_W-1:0]     sample_col;
  logic [e2c_pkg::SROW_W-1:0]     sample_row;
  logic [e2c_pkg::SUB_W-1:0]      sub_index;
  logic                           last;

  modport source (output valid, sample_col, sample_row, sub_index, last, input ready);
  modport sink   (input valid, sample_col, sample_row, sub_index, last, output ready);
endinterface

/* hdl/e2c_cfg_if.sv */
// Configuration write channel: register index and write data.
interface e2c_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [e2c_pkg::CFG_IDX_W-1:0]    index;
  logic [e2c_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/equirect_to_cube_sample_address.sv */
// Top level: cube face pixel to equirectangular sample addresses, as a pipeline of cells.
//
// Usage: each item on in_chan names a cube face pixel (face, col, row). The block
// emits SUPERSAMPLE*SUPERSAMPLE items on out_chan, one per supersampling grid point,
// with sub_index counting the points and last marking the final one of the pixel.
// cfg_chan writes face_size, map_width and map_height; it is ready whenever reset is
// released, and writes belong in times when no request is in flight.
// Throughput: one result per cycle while out_chan takes results; a new request is
// taken in the cycle its predecessor issues its last grid point, so requests follow
// each other with no gap.
// The path from an accepted request runs through the sequencer, an 18-cell divider
// row, a square root row beside the longitude CORDIC row, then the latitude row.
// Reset returns the registers to 1024 / 4096 / 2048 and empties the pipeline.
// When out_chan stalls, the whole cell row holds and in_chan drops ready; the output
// register keeps the waiting result and nothing is lost.
module equirect_to_cube_sample_address #(
  parameter int SUPERSAMPLE  = e2c_pkg::SUPERSAMPLE_DEF,
  parameter int CORDIC_STEPS = e2c_pkg::CORDIC_STEPS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  e2c_in_if.sink       in_chan,
  e2c_out_if.source    out_chan,
  e2c_cfg_if.sink      cfg_chan
);
  import e2c_pkg::*;

  localparam int IW = (SUPERSAMPLE > 1) ? $clog2(SUPERSAMPLE) : 1;
  localparam int LA = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;
  localparam int CS = CORDIC_STEPS;
  localparam int PW = A_W + MW_W;
  localparam int RW = A_W + MH_W;

  // Configuration registers hold already clamped values.
  logic [FS_W-1:0]  fs_r, fs_wr;
  logic [MW_W-1:0]  mw_r, mw_wr;
  logic [MH_W-1:0]  mh_r, mh_wr;
  logic [DVS_W-1:0] dvs;

  assign cfg_chan.ready = rst_n;

  always_comb begin
    fs_wr = cfg_chan.data[FS_W-1:0];
    if (fs_wr == '0) fs_wr = FS_W'(1);
    else if (fs_wr > FS_W'(FS_MAX)) fs_wr = FS_W'(FS_MAX);
    mw_wr = cfg_chan.data[MW_W-1:0];
    if (mw_wr == '0) mw_wr = MW_W'(1);
    else if (mw_wr > MW_W'(MW_MAX)) mw_wr = MW_W'(MW_MAX);
    mh_wr = cfg_chan.data[MH_W-1:0];
    if (mh_wr == '0) mh_wr = MH_W'(1);
    else if (mh_wr > MH_W'(MH_MAX)) mh_wr = MH_W'(MH_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_W'(1024);
      mw_r <= MW_W'(4096);
      mh_r <= MH_W'(2048);
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_FACE_SIZE:  fs_r <= fs_wr;
        REG_MAP_WIDTH:  mw_r <= mw_wr;
        REG_MAP_HEIGHT: mh_r <= mh_wr;
        default: ;
      endcase
    end
  end

  assign dvs = DVS_W'(int'(fs_r) * SUPERSAMPLE);

  // Pipeline advance and request sequencer.
  logic              adv;
  logic              busy_r;
  logic [IW-1:0]     i_r, j_r;
  logic [FACE_W-1:0] face_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              last_issue, accept;
  logic [DIV_W-1:0]  num_u, num_v;
  logic              sat_u, sat_v;
  logic              out_valid_r;

  assign adv        = !out_valid_r || out_chan.ready;
  assign last_issue = busy_r && (i_r == IW'(SUPERSAMPLE - 1)) && (j_r == IW'(SUPERSAMPLE - 1));
  assign in_chan.ready = rst_n && adv && (!busy_r || last_issue);
  assign accept     = in_chan.valid && in_chan.ready;

  assign num_u = {16'(2 * SUPERSAMPLE * int'(col_r) + 2 * int'(i_r) + 1), 16'h0000};
  assign num_v = {16'(2 * SUPERSAMPLE * int'(row_r) + 2 * int'(j_r) + 1), 16'h0000};
  assign sat_u = (DIV_W+2)'(num_u) >= ((DIV_W+2)'(dvs) << QB);
  assign sat_v = (DIV_W+2)'(num_v) >= ((DIV_W+2)'(dvs) << QB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      j_r    <= '0;
    end else if (busy_r && adv) begin
      if (last_issue) begin
        busy_r <= 1'b0;
      end else if (j_r == IW'(SUPERSAMPLE - 1)) begin
        j_r <= '0;
        i_r <= i_r + IW'(1);
      end else begin
        j_r <= j_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      face_r <= in_chan.face;
      col_r  <= in_chan.col;
      row_r  <= in_chan.row;
    end
  end

  // Divider row.
  side_t sd [QB+1];
  div_t  du [QB+1];
  div_t  dv [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd[0] <= '0;
    end else if (adv) begin
      sd[0].vld  <= busy_r;
      sd[0].face <= face_r;
      sd[0].sub  <= SUB_W'(int'(i_r) * SUPERSAMPLE + int'(j_r));
      sd[0].last <= last_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      du[0] <= '{rem: num_u, q: '0, sat: sat_u};
      dv[0] <= '{rem: num_v, q: '0, sat: sat_v};
    end
  end

  for (genvar t = 0; t < QB; t++) begin : g_div
    e2c_div_cell #(.B(QB - 1 - t)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d     (dvs),
      .u_in  (du[t]),
      .v_in  (dv[t]),
      .u_out (du[t+1]),
      .v_out (dv[t+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sd[t+1] <= '0;
      else if (adv) sd[t+1] <= sd[t];
    end
  end

  // Coordinates and face axes.
  logic signed [Q_W-1:0] uq, vq, xm, ym, zm;
  logic signed [Q_W-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic [2*Q_W-1:0]      xx2_r, yy2_r;
  side_t                 s1_r, s2_r;

  assign uq = grid_val(du[QB]);
  assign vq = grid_val(dv[QB]);

  always_comb begin
    case (face_t'(sd[QB].face))
      FACE_PY: begin xm = -uq;             ym = Q_W'(ONE_Q);  zm = vq;             end
      FACE_NX: begin xm = -Q_W'(ONE_Q);    ym = -uq;          zm = vq;             end
      FACE_NY: begin xm = uq;              ym = -Q_W'(ONE_Q); zm = vq;             end
      FACE_NZ: begin xm = vq;              ym = uq;           zm = -Q_W'(ONE_Q);   end
      FACE_PZ: begin xm = -vq;             ym = uq;           zm = Q_W'(ONE_Q);    end
      default: begin xm = Q_W'(ONE_Q);     ym = uq;           zm = vq;             end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (adv) begin
      s1_r <= sd[QB];
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= xm;
      y1_r  <= ym;
      z1_r  <= zm;
      xx2_r <= x1_r * x1_r;
      yy2_r <= y1_r * y1_r;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
    end
  end

  // Square root row beside the longitude CORDIC row.
  sqrt_t                 sqa [LA+1];
  cordic_t               lca [LA+1];
  logic signed [Q_W-1:0] za  [LA+1];
  side_t                 sa  [LA+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sa[0] <= '0;
    else if (adv) sa[0] <= s2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa[0] <= '{n: SQ_W'(xx2_r) + SQ_W'(yy2_r), res: '0};
      lca[0] <= cordic_pre({{(CX_W-Q_W){x2_r[Q_W-1]}}, x2_r},
                           {{(CX_W-Q_W){y2_r[Q_W-1]}}, y2_r});
      za[0]  <= z2_r;
    end
  end

  for (genvar k = 0; k < LA; k++) begin : g_rowa
    if (k < SQ_STEPS) begin : g_sq
      e2c_sqrt_cell #(.B(SQ_STEPS - 1 - k)) u_sq (
        .clk   (clk),
        .en    (adv),
        .s_in  (sqa[k]),
        .s_out (sqa[k+1])
      );
    end else begin : g_sq_hold
      always_ff @(posedge clk) begin
        if (adv) sqa[k+1] <= sqa[k];
      end
    end
    if (k < CS) begin : g_lon
      e2c_cordic_cell #(.K(k)) u_lon (
        .clk   (clk),
        .en    (adv),
        .c_in  (lca[k]),
        .c_out (lca[k+1])
      );
    end else begin : g_lon_hold
      always_ff @(posedge clk) begin
        if (adv) lca[k+1] <= lca[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) za[k+1] <= za[k];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sa[k+1] <= '0;
      else if (adv) sa[k+1] <= sa[k];
    end
  end

  // Latitude CORDIC row; the radius is never negative.
  cordic_t               lcb  [CS+1];
  logic signed [A_W-1:0] lonb [CS+1];
  side_t                 sb   [CS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sb[0] <= '0;
    else if (adv) sb[0] <= sa[LA];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lcb[0]  <= cordic_pre({1'b0, sqa[LA].res[CX_W-2:0]},
                            {{(CX_W-Q_W){za[LA][Q_W-1]}}, za[LA]});
      lonb[0] <= lca[LA].zero ? '0 : lca[LA].ang;
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_rowb
    e2c_cordic_cell #(.K(k)) u_lat (
      .clk   (clk),
      .en    (adv),
      .c_in  (lcb[k]),
      .c_out (lcb[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) lonb[k+1] <= lonb[k];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sb[k+1] <= '0;
      else if (adv) sb[k+1] <= sb[k];
    end
  end

  // Scaling to map size, then clamping into the output register.
  logic signed [A_W-1:0] latv;
  logic signed [A_W:0]   tcol, trow;
  logic [PW-1:0]         pcol_r;
  logic [RW-1:0]         prow_r;
  logic                  ncol_r, nrow_r;
  side_t                 s5_r;
  logic [PW-FRAC-2:0]    cshift;
  logic [RW-FRAC-1:0]    rshift;
  logic [SCOL_W-1:0]     scol_nxt, out_col_r;
  logic [SROW_W-1:0]     srow_nxt, out_row_r;
  logic [SUB_W-1:0]      out_sub_r;
  logic                  out_last_r;

  assign latv = lcb[CS].zero ? '0 : lcb[CS].ang;
  assign tcol = (A_W+1)'(lonb[CS]) + (A_W+1)'(ONE_Q);
  assign trow = (A_W+1)'(latv) + (A_W+1)'(HALF_Q);

  always_ff @(posedge clk) begin
    if (!rst_n) s5_r <= '0;
    else if (adv) s5_r <= sb[CS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ncol_r <= tcol[A_W];
      nrow_r <= trow[A_W];
      pcol_r <= PW'(tcol[A_W-1:0]) * PW'(mw_r);
      prow_r <= RW'(trow[A_W-1:0]) * RW'(mh_r);
    end
  end

  assign cshift = pcol_r[PW-1:FRAC+1];
  assign rshift = prow_r[RW-1:FRAC];

  always_comb begin
    if (ncol_r) scol_nxt = '0;
    else if (cshift >= (PW-FRAC-1)'(mw_r)) scol_nxt = SCOL_W'(mw_r - MW_W'(1));
    else scol_nxt = SCOL_W'(cshift);
    if (nrow_r) srow_nxt = '0;
    else if (rshift >= (RW-FRAC)'(mh_r)) srow_nxt = SROW_W'(mh_r - MH_W'(1));
    else srow_nxt = SROW_W'(rshift);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= s5_r.vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_col_r  <= scol_nxt;
      out_row_r  <= srow_nxt;
      out_sub_r  <= s5_r.sub;
      out_last_r <= s5_r.last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_col = out_col_r;
  assign out_chan.sample_row = out_row_r;
  assign out_chan.sub_index  = out_sub_r;
  assign out_chan.last       = out_last_r;
endmodule

/* hdl/e2c_div_cell.sv */
// Divider cell: one restoring quotient bit for the u and v lanes side by side.
module e2c_div_cell #(
  parameter int B = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [e2c_pkg::DVS_W-1:0] d,
  input  e2c_pkg::div_t             u_in,
  input  e2c_pkg::div_t             v_in,
  output e2c_pkg::div_t             u_out,
  output e2c_pkg::div_t             v_out
);
  import e2c_pkg::*;

  localparam int CW = DIV_W + 2;

  logic [CW-1:0] dsh;
  div_t          u_nxt, v_nxt, u_r, v_r;

  function automatic div_t step(input div_t a, input logic [CW-1:0] s);
    div_t r;
    r = a;
    if ({2'b00, a.rem} >= s) begin
      r.rem  = a.rem - s[DIV_W-1:0];
      r.q[B] = 1'b1;
    end
    return r;
  endfunction

  assign dsh   = CW'(d) << B;
  assign u_nxt = step(u_in, dsh);
  assign v_nxt = step(v_in, dsh);

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign u_out = u_r;
  assign v_out = v_r;
endmodule

/* hdl/e2c_sqrt_cell.sv */
// Square root cell: one result bit of the digit-by-digit integer square root.
module e2c_sqrt_cell #(
  parameter int B = 0
) (
  input  logic           clk,
  input  logic           en,
  input  e2c_pkg::sqrt_t s_in,
  output e2c_pkg::sqrt_t s_out
);
  import e2c_pkg::*;

  logic [SQ_W-1:0] bitv, trial;
  sqrt_t           s_nxt, s_r;

  assign bitv  = SQ_W'(1) << (2 * B);
  assign trial = s_in.res + bitv;

  always_comb begin
    s_nxt = s_in;
    if (s_in.n >= trial) begin
      s_nxt.n   = s_in.n - trial;
      s_nxt.res = (s_in.res >> 1) + bitv;
    end else begin
      s_nxt.res = s_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;
endmodule

/* hdl/e2c_cordic_cell.sv */
// CORDIC cell: one vectoring micro-rotation with its arctangent step.
module e2c_cordic_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             en,
  input  e2c_pkg::cordic_t c_in,
  output e2c_pkg::cordic_t c_out
);
  import e2c_pkg::*;

  logic signed [CX_W-1:0] xsh, ysh;
  logic signed [A_W-1:0]  t;
  cordic_t                c_nxt, c_r;

  assign xsh = $signed(c_in.x) >>> K;
  assign ysh = $signed(c_in.y) >>> K;
  assign t   = atan_tab(K);

  always_comb begin
    c_nxt = c_in;
    if (!c_in.y[CX_W-1]) begin
      c_nxt.x   = c_in.x + ysh;
      c_nxt.y   = c_in.y - xsh;
      c_nxt.ang = c_in.ang + t;
    end else begin
      c_nxt.x   = c_in.x - ysh;
      c_nxt.y   = c_in.y + xsh;
      c_nxt.ang = c_in.ang - t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;
endmodule
